>>> hdl/pwlom_pkg.sv
package pwlom_pkg;

    localparam int POS_W   = 16;
    localparam int LVL_W   = 8;
    localparam int DATA_W  = POS_W + LVL_W;
    localparam int OUT_W   = 8;
    localparam int PROD_W  = LVL_W + POS_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int STEP_W  = $clog2(OUT_W);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        logic [LVL_W-1:0] level;
    } item_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] position;
    } point_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_SCAN,
        ST_LK_MUL,
        ST_LK_SUM,
        ST_LK_DIV,
        ST_INS_SHIFT,
        ST_INS_HEAD
    } state_t;

endpackage

>>> hdl/pwlom_front.sv
module pwlom_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // position[15:0], level[23:16]
    input  logic                   s_tuser,   // kind
    output logic                   q_valid,
    input  logic                   q_ready,
    output pwlom_pkg::item_t       q_item
);
    import pwlom_pkg::*;

    item_t       slot_reg [2];
    item_t       slot_next [2];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    item_t       in_item;
    logic        push;
    logic        pop;

    // classify the incoming transfer
    always_comb begin
        in_item.op       = s_tuser ? OP_LOOKUP : OP_INSERT;
        in_item.position = s_tdata[POS_W-1:0];
        in_item.level    = s_tdata[DATA_W-1:POS_W];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[0];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_reg;
        unique case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    slot_next[0] = in_item;
                end else begin
                    slot_next[1] = in_item;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                slot_next[0] = slot_reg[1];
                cnt_next     = cnt_reg - 2'd1;
            end
            2'b11: begin
                slot_next[0] = in_item;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/pwlom_back.sv
module pwlom_back #(
    parameter int MAX_POINTS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  pwlom_pkg::item_t       q_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // opacity
    output logic                   m_tuser    // dropped
);
    import pwlom_pkg::*;

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    point_t              mem_reg [MAX_POINTS];
    point_t              rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    point_t              wr_data;

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                issue_reg, issue_next;
    logic                dv_reg, dv_next;
    logic [AW-1:0]       didx_reg, didx_next;
    point_t              prev_reg, prev_next;
    logic [POS_W-1:0]    x0_reg, x0_next, x1_reg, x1_next;
    logic [LVL_W-1:0]    y0_reg, y0_next, y1_reg, y1_next;
    logic [POS_W-1:0]    den_reg, den_next;
    logic [PROD_W-1:0]   prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic                neg_reg, neg_next;
    logic [NUM_W-1:0]    rem_reg, rem_next, sd_reg, sd_next;
    logic [OUT_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_opacity_reg, out_opacity_next;
    logic                out_dropped_reg, out_dropped_next;

    logic [CW-1:0]       addr_inc;
    logic [AW-1:0]       last_idx;
    logic [POS_W-1:0]    den;
    logic [POS_W-1:0]    dx;
    logic [LVL_W-1:0]    dy;
    logic [PROD_W-1:0]   num;
    logic                ge;
    point_t              new_point;

    assign q_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_opacity_reg;
    assign m_tuser  = out_dropped_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        issue_next       = issue_reg;
        didx_next        = didx_reg;
        prev_next        = prev_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y0_next          = y0_reg;
        y1_next          = y1_reg;
        den_next         = den_reg;
        prod_a_next      = prod_a_reg;
        prod_b_next      = prod_b_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        sd_next          = sd_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_opacity_next = out_opacity_reg;
        out_dropped_next = out_dropped_reg;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = rd_data_reg;
        new_point.level    = item_reg.level;
        new_point.position = item_reg.position;
        addr_inc         = CW'(addr_reg) + 1'b1;
        last_idx         = AW'(count_reg - 1'b1);
        den              = x1_reg - x0_reg;
        dx               = item_reg.position - x0_reg;
        dy               = (y1_reg >= y0_reg) ? (y1_reg - y0_reg) : (y0_reg - y1_reg);
        num              = neg_reg ? (prod_a_reg - prod_b_reg) : (prod_a_reg + prod_b_reg);
        ge               = (rem_reg >= sd_reg);

        unique case (state_reg)
            ST_IDLE: begin
                issue_next = 1'b0;
                if (q_valid && q_ready) begin
                    item_next = q_item;
                    if (q_item.op == OP_LOOKUP) begin
                        if (count_reg < CW'(2)) begin
                            out_valid_next   = 1'b1;
                            out_opacity_next = '0;
                            out_dropped_next = 1'b0;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            addr_next  = AW'(1);
                            issue_next = 1'b1;
                            state_next = ST_LK_SCAN;
                        end
                    end else if (count_reg == CW'(MAX_POINTS)) begin
                        out_valid_next   = 1'b1;
                        out_opacity_next = '0;
                        out_dropped_next = 1'b1;
                    end else if (count_reg == '0) begin
                        wr_en              = 1'b1;
                        wr_addr            = '0;
                        wr_data.level      = q_item.level;
                        wr_data.position   = q_item.position;
                        count_next         = count_reg + 1'b1;
                        out_valid_next     = 1'b1;
                        out_opacity_next   = '0;
                        out_dropped_next   = 1'b0;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = last_idx;
                        addr_next  = last_idx - 1'b1;
                        issue_next = (last_idx != '0);
                        state_next = ST_INS_SHIFT;
                    end
                end
            end
            ST_LK_SCAN: begin
                if (issue_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg;
                    addr_next  = addr_inc[AW-1:0];
                    issue_next = (addr_inc < count_reg);
                end
                if (dv_reg) begin
                    prev_next = rd_data_reg;
                    if ((didx_reg != '0) &&
                        ((rd_data_reg.position > item_reg.position) ||
                         (CW'(didx_reg) == count_reg - 1'b1))) begin
                        x0_next    = prev_reg.position;
                        y0_next    = prev_reg.level;
                        x1_next    = rd_data_reg.position;
                        y1_next    = rd_data_reg.level;
                        issue_next = 1'b0;
                        state_next = ST_LK_MUL;
                    end
                end
            end
            ST_LK_MUL: begin
                den_next    = den;
                neg_next    = (y1_reg < y0_reg);
                prod_a_next = PROD_W'(y0_reg) * PROD_W'(den);
                prod_b_next = PROD_W'(dy) * PROD_W'(dx);
                if ((item_reg.position < x0_reg) || (item_reg.position > x1_reg)) begin
                    out_valid_next   = 1'b1;
                    out_opacity_next = '0;
                    out_dropped_next = 1'b0;
                    state_next       = ST_IDLE;
                end else if (den == '0) begin
                    out_valid_next   = 1'b1;
                    out_opacity_next = y1_reg;
                    out_dropped_next = 1'b0;
                    state_next       = ST_IDLE;
                end else begin
                    state_next = ST_LK_SUM;
                end
            end
            ST_LK_SUM: begin
                // rounded quotient of (2*num + den) / (2*den), always below 256
                rem_next   = {num, 1'b0} + NUM_W'(den_reg);
                sd_next    = {1'b0, den_reg, 1'b0, {(OUT_W-1){1'b0}}};
                quo_next   = '0;
                step_next  = STEP_W'(OUT_W - 1);
                state_next = ST_LK_DIV;
            end
            ST_LK_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - sd_reg;
                end
                quo_next = {quo_reg[OUT_W-2:0], ge};
                sd_next  = sd_reg >> 1;
                if (step_reg == '0) begin
                    out_valid_next   = 1'b1;
                    out_opacity_next = {quo_reg[OUT_W-2:0], ge};
                    out_dropped_next = 1'b0;
                    state_next       = ST_IDLE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_INS_SHIFT: begin
                if (issue_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg;
                    addr_next  = addr_reg - 1'b1;
                    issue_next = (addr_reg != '0);
                end
                if (dv_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = didx_reg + 1'b1;
                    if (rd_data_reg.position > item_reg.position) begin
                        wr_data = rd_data_reg;
                        if (didx_reg == '0) begin
                            issue_next = 1'b0;
                            state_next = ST_INS_HEAD;
                        end
                    end else begin
                        wr_data          = new_point;
                        issue_next       = 1'b0;
                        count_next       = count_reg + 1'b1;
                        out_valid_next   = 1'b1;
                        out_opacity_next = '0;
                        out_dropped_next = 1'b0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_INS_HEAD: begin
                wr_en            = 1'b1;
                wr_addr          = '0;
                wr_data          = new_point;
                count_next       = count_reg + 1'b1;
                out_valid_next   = 1'b1;
                out_opacity_next = '0;
                out_dropped_next = 1'b0;
                state_next       = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        dv_next   = rd_en;
        didx_next = rd_addr;
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        addr_reg        <= addr_next;
        didx_reg        <= didx_next;
        prev_reg        <= prev_next;
        x0_reg          <= x0_next;
        x1_reg          <= x1_next;
        y0_reg          <= y0_next;
        y1_reg          <= y1_next;
        den_reg         <= den_next;
        prod_a_reg      <= prod_a_next;
        prod_b_reg      <= prod_b_next;
        neg_reg         <= neg_next;
        rem_reg         <= rem_next;
        sd_reg          <= sd_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        out_opacity_reg <= out_opacity_next;
        out_dropped_reg <= out_dropped_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above table size");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_dropped_reg |-> out_opacity_reg == '0)
        else $error("dropped insert with nonzero opacity");

    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LK_DIV || state_reg == ST_INS_HEAD) |-> !out_valid_reg)
        else $error("result slot busy while an item is in flight");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg < CW'(MAX_POINTS))
        else $error("table write with full table");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("point count moved by other than one");

endmodule

>>> hdl/piecewise_linear_opacity_map.sv
// lookup: scans the stored points in order, then passes the multiply, sum and divide states
// lookup outside the span or on equal positions: answered from the multiply state, no divide
// insert: shifts later points up, writes the point; full/empty table, short lookup: from idle
// items are taken only in idle; idle-answered items go one per cycle while results are taken
// input transfers enter a two-entry queue and are taken while a result waits
// synchronous reset clears the point count, queue and handshake state; table contents stay
module piecewise_linear_opacity_map #(
    parameter int MAX_POINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // position[15:0], level[23:16]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // opacity[7:0]
    output logic        m_tuser    // dropped
);
    import pwlom_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    pwlom_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pwlom_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import pwlom_pkg::*;

    localparam int MAX_POINTS  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REQS = 1450;

    typedef struct packed {
        logic [7:0] opacity;
        logic       dropped;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // position[15:0], level[23:16]
    logic        s_tuser  = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // opacity[7:0]
    logic        m_tuser;         // dropped

    item_t       queued_requests[$];
    outcome_t    awaited_outcomes[$];
    logic [15:0] knot_pos[MAX_POINTS];
    logic [7:0]  knot_lvl[MAX_POINTS];
    int          knot_count = 0;
    logic [15:0] inserted_positions[$];

    int       errors      = 0;
    int       idle_cycles = 0;
    int       send_wait   = 0;
    int       take_wait   = 0;
    int       take_draw;
    bit       send_steady = 1'b0;
    bit       take_steady = 1'b0;
    bit       s_fire;
    item_t    next_req;
    outcome_t got;
    outcome_t want;

    piecewise_linear_opacity_map #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] interpolate_opacity(logic [15:0] v);
        int     i;
        longint x0, x1, y0, y1, den, num;
        if (knot_count < 2) return 8'd0;
        i = 1;
        while (i < knot_count && knot_pos[i] <= v) i++;
        if (i == knot_count) i--;
        x0 = knot_pos[i-1];
        x1 = knot_pos[i];
        y0 = knot_lvl[i-1];
        y1 = knot_lvl[i];
        if (longint'(v) < x0 || longint'(v) > x1) return 8'd0;
        den = x1 - x0;
        if (den == 0) return knot_lvl[i];
        num = y0 * den + (y1 - y0) * (longint'(v) - x0);
        num = (2 * num + den) / (2 * den);
        if (num > 255) num = 255;
        return num[7:0];
    endfunction

    function automatic outcome_t opacity_map_step(item_t req);
        outcome_t res;
        int       k;
        int       j;
        res = '0;
        if (req.op == OP_LOOKUP) begin
            res.opacity = interpolate_opacity(req.position);
        end else if (knot_count >= MAX_POINTS) begin
            res.dropped = 1'b1;
        end else begin
            k = 0;
            while (k < knot_count && knot_pos[k] <= req.position) k++;
            for (j = knot_count; j > k; j--) begin
                knot_pos[j] = knot_pos[j-1];
                knot_lvl[j] = knot_lvl[j-1];
            end
            knot_pos[k] = req.position;
            knot_lvl[k] = req.level;
            knot_count++;
        end
        return res;
    endfunction

    function automatic void add_request(op_t op, int pos, int lvl);
        item_t req;
        req.op       = op;
        req.position = pos[15:0];
        req.level    = lvl[7:0];
        queued_requests = {queued_requests, req};
        if (op == OP_INSERT) inserted_positions = {inserted_positions, pos[15:0]};
    endfunction

    task automatic wait_drained();
        while (queued_requests.size() != 0 || s_tvalid || awaited_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= $urandom_range(0, 7);
        end else begin
            s_fire = s_tvalid && s_tready;
            if (s_fire) begin
                awaited_outcomes = {awaited_outcomes,
                    opacity_map_step(item_t'({s_tuser, s_tdata[15:0], s_tdata[23:16]}))};
            end
            if (!s_tvalid || s_fire) begin
                if (send_wait > 0) begin
                    s_tvalid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (queued_requests.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    next_req = queued_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.op;
                    s_tdata  <= {next_req.level, next_req.position};
                    if ($urandom_range(0, 99) == 0) send_steady <= !send_steady;
                    send_wait <= send_steady ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            take_wait <= $urandom_range(0, 7);
        end else if (m_tvalid && m_tready) begin
            got.opacity = m_tdata;
            got.dropped = m_tuser;
            if (awaited_outcomes.size() == 0) begin
                errors++;
                $error("unexpected transfer: opacity %0d dropped %0d", got.opacity, got.dropped);
            end else begin
                want = awaited_outcomes.pop_front();
                if (got.opacity !== want.opacity) begin
                    errors++;
                    $error("opacity: expected %0d, actual %0d", want.opacity, got.opacity);
                end
                if (got.dropped !== want.dropped) begin
                    errors++;
                    $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
                end
            end
            if ($urandom_range(0, 99) == 0) take_steady <= !take_steady;
            take_draw = take_steady ? 0 : $urandom_range(0, 7);
            m_tready  <= (take_draw == 0);
            take_wait <= take_draw;
        end else if (!m_tready) begin
            if (take_wait <= 1) m_tready <= 1'b1;
            if (take_wait > 0) take_wait <= take_wait - 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int r;
        int p;

        // empty table, single point, then a growing table
        add_request(OP_LOOKUP, 0, 255);
        add_request(OP_INSERT, 40000, 200);
        add_request(OP_LOOKUP, 40000, 0);
        add_request(OP_INSERT, 20000, 50);
        add_request(OP_LOOKUP, 30000, 17);
        add_request(OP_LOOKUP, 65535, 255);
        // equal positions go after the earlier one
        add_request(OP_INSERT, 30000, 255);
        add_request(OP_INSERT, 30000, 0);
        add_request(OP_LOOKUP, 30000, 99);
        // equal last pair: lookup there gives the upper level
        add_request(OP_INSERT, 60000, 10);
        add_request(OP_INSERT, 60000, 240);
        add_request(OP_LOOKUP, 60000, 3);
        add_request(OP_INSERT, 1000, 0);
        add_request(OP_LOOKUP, 0, 128);
        add_request(OP_INSERT, 5000, 255);
        add_request(OP_INSERT, 10000, 128);
        add_request(OP_INSERT, 10001, 127);
        add_request(OP_INSERT, 25000, 1);
        add_request(OP_INSERT, 45000, 254);
        add_request(OP_INSERT, 50000, 85);
        add_request(OP_INSERT, 50500, 170);
        add_request(OP_INSERT, 2000, 64);
        add_request(OP_INSERT, 55000, 32);
        // table full
        add_request(OP_INSERT, 65535, 255);
        add_request(OP_INSERT, 0, 0);
        add_request(OP_LOOKUP, 50250, 200);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait_drained();
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                add_request(OP_INSERT, $urandom_range(0, 65535), $urandom_range(0, 255));
            end else begin
                if (r < 45) begin
                    p = int'(inserted_positions[$urandom_range(0, inserted_positions.size() - 1)]);
                    p = p + $urandom_range(0, 6) - 3;
                    if (p < 0) p = 0;
                    if (p > 65535) p = 65535;
                end else if (r < 60) begin
                    p = $urandom_range(0, 65535);
                end else begin
                    p = $urandom_range(900, 61000);
                end
                add_request(OP_LOOKUP, p, $urandom_range(0, 255));
            end
        end
        wait_drained();
        repeat (60) @(negedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
